// ===== hw/rtl/rne_pkg.sv =====
`default_nettype none
package rne_pkg;

  localparam int ValueW = 12;
  localparam int SymW   = 8;
  localparam int DigitW = 4;
  localparam int PlaceW = 2;
  localparam int MultW  = 14;

  localparam logic [ValueW-1:0] ValueLimit = 12'd4000;

  localparam logic [SymW-1:0] ChM = "M";
  localparam logic [SymW-1:0] ChD = "D";
  localparam logic [SymW-1:0] ChC = "C";
  localparam logic [SymW-1:0] ChL = "L";
  localparam logic [SymW-1:0] ChX = "X";
  localparam logic [SymW-1:0] ChV = "V";
  localparam logic [SymW-1:0] ChI = "I";
  localparam logic [SymW-1:0] ChNone = 8'd0;

  localparam logic [PlaceW-1:0] PlaceThou = 2'd0;
  localparam logic [PlaceW-1:0] PlaceHund = 2'd1;
  localparam logic [PlaceW-1:0] PlaceTens = 2'd2;
  localparam logic [PlaceW-1:0] PlaceUnit = 2'd3;

  typedef enum logic [3:0] {
    A_NONE,
    A_LOAD,
    A_EXTRACT,
    A_NEXT_PLACE,
    A_EMIT_ONE,
    A_EMIT_ONE_DEC,
    A_EMIT_FIVE_SUB5,
    A_EMIT_FIVE_END,
    A_EMIT_TEN_END,
    A_EMIT_ERR,
    A_EMIT_EMPTY
  } act_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_INPUT,
    C_ERR,
    C_REM_ZERO,
    C_DIG4,
    C_DIG9,
    C_DIG_LT5,
    C_DIG0
  } cond_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_ERR,
    S_CHK_ZERO,
    S_EXTRACT,
    S_DISP4,
    S_DISP9,
    S_DISP5,
    S_ONES,
    S_FOUR_A,
    S_FOUR_B,
    S_NINE_A,
    S_NINE_B,
    S_NEXT_PLACE,
    S_ERR_OUT,
    S_ZERO_OUT
  } step_t;

  // Condition true: jump to t_true, no action. Otherwise do act and go to t_false.
  typedef struct packed {
    cond_t cond;
    step_t t_true;
    step_t t_false;
    act_t  act;
  } ucode_t;

  typedef struct packed {
    act_t act;
    logic in_ready;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic err;
    logic rem_zero;
    logic dig4;
    logic dig9;
    logic dig_lt5;
    logic dig0;
    logic out_free;
  } status_t;

  function automatic ucode_t ucode_rom(step_t pc);
    ucode_t w;
    case (pc)
      S_IDLE:       w = '{C_NO_INPUT, S_IDLE,       S_CHK_ERR,    A_LOAD};
      S_CHK_ERR:    w = '{C_ERR,      S_ERR_OUT,    S_CHK_ZERO,   A_NONE};
      S_CHK_ZERO:   w = '{C_REM_ZERO, S_ZERO_OUT,   S_EXTRACT,    A_NONE};
      S_EXTRACT:    w = '{C_NEVER,    S_IDLE,       S_DISP4,      A_EXTRACT};
      S_DISP4:      w = '{C_DIG4,     S_FOUR_A,     S_DISP9,      A_NONE};
      S_DISP9:      w = '{C_DIG9,     S_NINE_A,     S_DISP5,      A_NONE};
      S_DISP5:      w = '{C_DIG_LT5,  S_ONES,       S_ONES,       A_EMIT_FIVE_SUB5};
      S_ONES:       w = '{C_DIG0,     S_NEXT_PLACE, S_ONES,       A_EMIT_ONE_DEC};
      S_FOUR_A:     w = '{C_NEVER,    S_IDLE,       S_FOUR_B,     A_EMIT_ONE};
      S_FOUR_B:     w = '{C_NEVER,    S_IDLE,       S_NEXT_PLACE, A_EMIT_FIVE_END};
      S_NINE_A:     w = '{C_NEVER,    S_IDLE,       S_NINE_B,     A_EMIT_ONE};
      S_NINE_B:     w = '{C_NEVER,    S_IDLE,       S_NEXT_PLACE, A_EMIT_TEN_END};
      S_NEXT_PLACE: w = '{C_REM_ZERO, S_IDLE,       S_EXTRACT,    A_NEXT_PLACE};
      S_ERR_OUT:    w = '{C_NEVER,    S_IDLE,       S_IDLE,       A_EMIT_ERR};
      S_ZERO_OUT:   w = '{C_NEVER,    S_IDLE,       S_IDLE,       A_EMIT_EMPTY};
      default:      w = '{C_NEVER,    S_IDLE,       S_IDLE,       A_NONE};
    endcase
    return w;
  endfunction

  function automatic logic is_emit(act_t a);
    logic r;
    case (a)
      A_EMIT_ONE, A_EMIT_ONE_DEC, A_EMIT_FIVE_SUB5, A_EMIT_FIVE_END,
      A_EMIT_TEN_END, A_EMIT_ERR, A_EMIT_EMPTY: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [9:0] place_weight(logic [PlaceW-1:0] place);
    logic [9:0] w;
    case (place)
      PlaceThou: w = 10'd1000;
      PlaceHund: w = 10'd100;
      PlaceTens: w = 10'd10;
      PlaceUnit: w = 10'd1;
      default:   w = 10'd1;
    endcase
    return w;
  endfunction

  function automatic logic [SymW-1:0] one_sym(logic [PlaceW-1:0] place);
    logic [SymW-1:0] s;
    case (place)
      PlaceThou: s = ChM;
      PlaceHund: s = ChC;
      PlaceTens: s = ChX;
      PlaceUnit: s = ChI;
      default:   s = ChNone;
    endcase
    return s;
  endfunction

  function automatic logic [SymW-1:0] five_sym(logic [PlaceW-1:0] place);
    logic [SymW-1:0] s;
    case (place)
      PlaceHund: s = ChD;
      PlaceTens: s = ChL;
      PlaceUnit: s = ChV;
      default:   s = ChNone;
    endcase
    return s;
  endfunction

  function automatic logic [SymW-1:0] ten_sym(logic [PlaceW-1:0] place);
    logic [SymW-1:0] s;
    case (place)
      PlaceHund: s = ChM;
      PlaceTens: s = ChC;
      PlaceUnit: s = ChX;
      default:   s = ChNone;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rne_if.sv =====
`default_nettype none
interface rne_in_if;
  import rne_pkg::*;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface rne_out_if;
  import rne_pkg::*;
  logic            valid;
  logic            ready;
  logic [SymW-1:0] symbol;
  logic            empty_res;
  logic            range_error;
  logic            last;
  modport source (output valid, output symbol, output empty_res, output range_error,
                  output last, input ready);
  modport sink (input valid, input symbol, input empty_res, input range_error,
                input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rne_sequencer.sv =====
`default_nettype none
module rne_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  rne_pkg::status_t st,
  output rne_pkg::ctrl_t   ctrl
);
  import rne_pkg::*;

  step_t  pc;
  step_t  pc_next;
  ucode_t uw;
  logic   cond_true;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    uw = ucode_rom(pc);
    case (uw.cond)
      C_NEVER:    cond_true = 1'b0;
      C_NO_INPUT: cond_true = !st.in_valid;
      C_ERR:      cond_true = st.err;
      C_REM_ZERO: cond_true = st.rem_zero;
      C_DIG4:     cond_true = st.dig4;
      C_DIG9:     cond_true = st.dig9;
      C_DIG_LT5:  cond_true = st.dig_lt5;
      C_DIG0:     cond_true = st.dig0;
      default:    cond_true = 1'b0;
    endcase

    pc_next       = pc;
    ctrl.act      = A_NONE;
    ctrl.in_ready = (pc == S_IDLE);
    if (cond_true) begin
      pc_next = uw.t_true;
    end else if (!(is_emit(uw.act) && !st.out_free)) begin
      // hold the step while the output register is still occupied
      ctrl.act = uw.act;
      pc_next  = uw.t_false;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rne_datapath.sv =====
`default_nettype none
module rne_datapath (
  input  logic             clk,
  input  logic             rst,
  input  rne_pkg::ctrl_t   ctrl,
  output rne_pkg::status_t st,
  rne_in_if.sink           in_req,
  rne_out_if.source        out_res
);
  import rne_pkg::*;

  logic [ValueW-1:0] rem;
  logic [DigitW-1:0] digit;
  logic [PlaceW-1:0] place;

  logic              out_valid;
  logic [SymW-1:0]   symbol;
  logic              empty_res;
  logic              range_error;
  logic              last;

  logic [9:0]        weight;
  logic [MultW-1:0]  mult;
  logic [DigitW-1:0] ext_digit;
  logic [MultW-1:0]  ext_sub;
  logic              rem_zero;

  logic              emit;
  logic [SymW-1:0]   symbol_next;
  logic              empty_next;
  logic              error_next;
  logic              last_next;

  // digit of the current place: highest multiple of the weight not above rem
  always_comb begin
    weight    = place_weight(place);
    ext_digit = '0;
    ext_sub   = '0;
    mult      = '0;
    for (int k = 1; k <= 9; k++) begin
      mult = MultW'(k) * {4'd0, weight};
      if ({2'd0, rem} >= mult) begin
        ext_digit = DigitW'(k);
        ext_sub   = mult;
      end
    end
  end

  assign rem_zero = (rem == '0);

  always_comb begin
    emit        = is_emit(ctrl.act);
    symbol_next = ChNone;
    empty_next  = 1'b0;
    error_next  = 1'b0;
    last_next   = 1'b0;
    case (ctrl.act)
      A_EMIT_ONE: begin
        symbol_next = one_sym(place);
      end
      A_EMIT_ONE_DEC: begin
        symbol_next = one_sym(place);
        last_next   = (digit == 4'd1) && rem_zero;
      end
      A_EMIT_FIVE_SUB5: begin
        symbol_next = five_sym(place);
        last_next   = (digit == 4'd5) && rem_zero;
      end
      A_EMIT_FIVE_END: begin
        symbol_next = five_sym(place);
        last_next   = rem_zero;
      end
      A_EMIT_TEN_END: begin
        symbol_next = ten_sym(place);
        last_next   = rem_zero;
      end
      A_EMIT_ERR: begin
        error_next = 1'b1;
        last_next  = 1'b1;
      end
      A_EMIT_EMPTY: begin
        empty_next = 1'b1;
        last_next  = 1'b1;
      end
      default: begin
        symbol_next = ChNone;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (ctrl.act)
      A_LOAD: begin
        rem   <= in_req.value;
        place <= PlaceThou;
      end
      A_EXTRACT: begin
        digit <= ext_digit;
        rem   <= rem - ext_sub[ValueW-1:0];
      end
      A_NEXT_PLACE:     place <= place + 2'd1;
      A_EMIT_ONE_DEC:   digit <= digit - 4'd1;
      A_EMIT_FIVE_SUB5: digit <= digit - 4'd5;
      default: begin
        digit <= digit;
      end
    endcase
    if (emit) begin
      symbol      <= symbol_next;
      empty_res   <= empty_next;
      range_error <= error_next;
      last        <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign in_req.ready        = ctrl.in_ready;
  assign out_res.valid       = out_valid;
  assign out_res.symbol      = symbol;
  assign out_res.empty_res   = empty_res;
  assign out_res.range_error = range_error;
  assign out_res.last        = last;

  assign st.in_valid = in_req.valid;
  assign st.err      = (rem >= ValueLimit);
  assign st.rem_zero = rem_zero;
  assign st.dig4     = (digit == 4'd4);
  assign st.dig9     = (digit == 4'd9);
  assign st.dig_lt5  = (digit < 4'd5);
  assign st.dig0     = (digit == 4'd0);
  assign st.out_free = !out_valid || out_res.ready;

endmodule
`default_nettype wire

// ===== hw/rtl/roman_numeral_encoder_unit.sv =====
// An out-of-range request passes the load, error-check and error-output steps before
// its result is registered; a zero request passes the load, error-check, zero-check and
// zero-output steps. Throughput: one request at a time; the micro-program issues one
// control word per cycle but holds an emit step while the output register is occupied;
// at most one character per cycle.
// Reset: synchronous rst returns the step counter to idle and empties the output register.
`default_nettype none
module roman_numeral_encoder_unit (
  input logic        clk,
  input logic        rst,
  rne_in_if.sink     in_req,
  rne_out_if.source  out_res
);
  import rne_pkg::*;

  ctrl_t   ctrl;
  status_t st;

  rne_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .st   (st),
    .ctrl (ctrl)
  );

  rne_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .st      (st),
    .in_req  (in_req),
    .out_res (out_res)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/rne_checker.sv =====
`default_nettype none
module rne_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] symbol,
  input logic       empty_res,
  input logic       range_error,
  input logic       last
);

  // one request at a time: no new request right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one still in work");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(symbol) && $stable(last)))
    else $error("stalled result changed");

  a_flag_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (empty_res || range_error)) |-> (last && symbol == 8'd0
      && !(empty_res && range_error)))
    else $error("empty or error result is not a lone final marker");

  a_char_present: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !empty_res && !range_error) |-> (symbol != 8'd0))
    else $error("character result without a symbol");

endmodule

bind roman_numeral_encoder_unit rne_checker u_rne_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .symbol      (out_res.symbol),
  .empty_res   (out_res.empty_res),
  .range_error (out_res.range_error),
  .last        (out_res.last)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rne_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int NumDirected = 25;
  localparam int NumRandom = 435;
  localparam int QuietFrom = 340;   // random items from here on run with no idling
  localparam int HoldAt = 200;      // random item at which the sink holds off
  localparam int HoldCycles = 400;
  localparam int TailCycles = 60;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            empty_res;
    logic            range_error;
    logic            last;
  } numeral_char_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              typed;
    logic [SymW-1:0]   symbol;
    logic              empty_res;
    logic              range_error;
  } stim_row_t;

  localparam logic [0:3][9:0]      PlaceWt = {10'd1000, 10'd100, 10'd10, 10'd1};
  localparam logic [0:3][SymW-1:0] OneCh   = {ChM, ChC, ChX, ChI};
  localparam logic [0:3][SymW-1:0] FiveCh  = {ChNone, ChD, ChL, ChV};
  localparam logic [0:3][SymW-1:0] TenCh   = {ChNone, ChM, ChC, ChX};

  // typed rows give one result with last set; the rest go through the predictor
  stim_row_t directed_rows [NumDirected] = '{
    '{12'd0,    1'b1, ChNone, 1'b1, 1'b0},
    '{12'd4000, 1'b1, ChNone, 1'b0, 1'b1},
    '{12'd4095, 1'b1, ChNone, 1'b0, 1'b1},
    '{12'd1,    1'b1, ChI,    1'b0, 1'b0},
    '{12'd5,    1'b1, ChV,    1'b0, 1'b0},
    '{12'd10,   1'b1, ChX,    1'b0, 1'b0},
    '{12'd50,   1'b1, ChL,    1'b0, 1'b0},
    '{12'd100,  1'b1, ChC,    1'b0, 1'b0},
    '{12'd500,  1'b1, ChD,    1'b0, 1'b0},
    '{12'd1000, 1'b1, ChM,    1'b0, 1'b0},
    '{12'd3999, 1'b0, ChNone, 1'b0, 1'b0},
    '{12'd3888, 1'b0, ChNone, 1'b0, 1'b0},
    '{12'd4,    1'b0, ChNone, 1'b0, 1'b0},
    '{12'd9,    1'b0, ChNone, 1'b0, 1'b0},
    '{12'd40,   1'b0, ChNone, 1'b0, 1'b0},
    '{12'd90,   1'b0, ChNone, 1'b0, 1'b0},
    '{12'd400,  1'b0, ChNone, 1'b0, 1'b0},
    '{12'd900,  1'b0, ChNone, 1'b0, 1'b0},
    '{12'd8,    1'b0, ChNone, 1'b0, 1'b0},
    '{12'd444,  1'b0, ChNone, 1'b0, 1'b0},
    '{12'd1994, 1'b0, ChNone, 1'b0, 1'b0},
    '{12'd2048, 1'b0, ChNone, 1'b0, 1'b0},
    '{12'd3000, 1'b0, ChNone, 1'b0, 1'b0},
    '{12'd1365, 1'b0, ChNone, 1'b0, 1'b0},
    '{12'd2730, 1'b0, ChNone, 1'b0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  rne_in_if  in_req();
  rne_out_if out_res();

  roman_numeral_encoder_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .in_req  (in_req),
    .out_res (out_res)
  );

  numeral_char_t expected_chars[$];
  int            mismatch_cnt = 0;
  int            cycle_cnt = 0;
  bit            idling = 1'b1;
  bit            long_hold_req = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void push_char(input logic [SymW-1:0] sym, input logic emp,
                                    input logic err);
    numeral_char_t c;
    c = '{sym, emp, err, 1'b0};
    expected_chars.push_back(c);
  endfunction

  function automatic void predict_numeral(input logic [ValueW-1:0] v);
    int rest;
    int d;
    if (v >= ValueLimit) begin
      push_char(ChNone, 1'b0, 1'b1);
    end else if (v == '0) begin
      push_char(ChNone, 1'b1, 1'b0);
    end else begin
      rest = int'(v);
      for (int p = 0; p < 4; p++) begin
        d = rest / int'(PlaceWt[p]);
        rest = rest % int'(PlaceWt[p]);
        if (d == 4) begin
          push_char(OneCh[p], 1'b0, 1'b0);
          push_char(FiveCh[p], 1'b0, 1'b0);
        end else if (d == 9) begin
          push_char(OneCh[p], 1'b0, 1'b0);
          push_char(TenCh[p], 1'b0, 1'b0);
        end else begin
          if (d >= 5) begin
            push_char(FiveCh[p], 1'b0, 1'b0);
            d -= 5;
          end
          for (int r = 0; r < d; r++) push_char(OneCh[p], 1'b0, 1'b0);
        end
      end
    end
    expected_chars[expected_chars.size()-1].last = 1'b1;
  endfunction

  // hold valid until the request is taken; gap only when idling is on
  task automatic send_request(input logic [ValueW-1:0] v);
    int gap;
    gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.value <= v;
    do @(posedge clk); while (!(in_req.valid === 1'b1 && in_req.ready === 1'b1));
  endtask

  // sink side: random stall bursts, plus one long hold-off on request
  initial begin
    out_res.ready <= 1'b0;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_res.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (idling && !rst && $urandom_range(0, 5) == 0) begin
        out_res.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_res.ready <= !rst;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    numeral_char_t got;
    numeral_char_t want;
    if (!rst && out_res.valid === 1'b1 && out_res.ready === 1'b1) begin
      got = '{out_res.symbol, out_res.empty_res, out_res.range_error, out_res.last};
      if (expected_chars.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected character: sym=%h empty=%b err=%b last=%b",
                   got.symbol, got.empty_res, got.range_error, got.last);
      end else begin
        want = expected_chars.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp sym=%h empty=%b err=%b last=%b, got sym=%h empty=%b err=%b last=%b",
                     want.symbol, want.empty_res, want.range_error, want.last,
                     got.symbol, got.empty_res, got.range_error, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [ValueW-1:0] v;
    int sel;
    in_req.valid <= 1'b0;
    in_req.value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].value);
      if (directed_rows[i].typed)
        expected_chars.push_back('{directed_rows[i].symbol, directed_rows[i].empty_res,
                                   directed_rows[i].range_error, 1'b1});
      else
        predict_numeral(directed_rows[i].value);
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n == HoldAt) long_hold_req = 1'b1;
      if (n == QuietFrom) idling = 1'b0;
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        v = '0;
      end else if (sel == 1) begin
        v = ValueW'($urandom_range(4000, 4095));
      end else if (sel <= 4) begin
        v = ValueW'($urandom_range(0, 4095));
      end else begin
        // build from decimal digits so every digit case turns up often
        v = ValueW'($urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100 +
                    $urandom_range(0, 9) * 10 + $urandom_range(0, 9));
      end
      send_request(v);
      predict_numeral(v);
    end
    in_req.valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/rne_pkg.sv
hw/rtl/rne_if.sv
hw/rtl/rne_sequencer.sv
hw/rtl/rne_datapath.sv
hw/rtl/roman_numeral_encoder_unit.sv
hw/rtl/rne_checker.sv
sim/tb_top.sv
